// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LPHI_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LPHI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lphi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphi_pkg
// Types, codes and constants of the linear-probe hash index.
// ----------------------------------------------------------------------------
package lphi_pkg;

   localparam int TABLE_BITS_DEF = 10;
   localparam int KEY_W          = 64;
   localparam int VALUE_W        = 10;
   localparam int SLOT_BITS_W    = 4;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_IDX_W      = 1;
   localparam int MIN_SLOT_BITS  = 4;

   localparam logic [KEY_W-1:0]       RESERVED_KEY    = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0]       HASH_MULT_RESET = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [SLOT_BITS_W-1:0] SLOT_BITS_RESET = 4'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MULT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BITS = 1'b1;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_RESERVED  = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   // partial products of the 64 x 64 (mod 2^64) hash multiply
   typedef enum logic [1:0] {
      MUL_LL  = 2'd0,
      MUL_LH  = 2'd1,
      MUL_HL  = 2'd2,
      MUL_ACC = 2'd3
   } mul_phase_type;

   typedef enum logic [1:0] {
      VAL_ZERO  = 2'd0,
      VAL_COUNT = 2'd1,
      VAL_SLOT  = 2'd2
   } val_sel_type;

   typedef struct packed {
      action_type       action;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] value;
   } rsp_type;

   typedef struct packed {
      logic               used;
      logic [VALUE_W-1:0] value;
      logic [KEY_W-1:0]   key;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic          load;
      logic          cnt_clr;
      logic          sweep;
      logic          mul_en;
      mul_phase_type mul_phase;
      logic          set_home;
      logic          rd;
      logic          adv;
      logic          wr;
      logic          rsp_load;
      status_type    rsp_status;
      val_sel_type   rsp_val;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      action_type action;
      logic       key_reserved;
      logic       slot_used;
      logic       key_match;
      logic       probe_last;
      logic       sweep_last;
      logic       full;
   } stat_type;

endpackage

// ===== design/lphi_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphi_datapath
// Config registers, shared hash multiplier, probe address logic, slot memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lphi_datapath #(
   parameter int TABLE_BITS = lphi_pkg::TABLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lphi_pkg::req_type                   req_item,
   input  lphi_pkg::cmd_type                   cmd,
   output lphi_pkg::stat_type                  stat,
   input  logic                                csr_we,
   input  logic [lphi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lphi_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_strobe,
   output lphi_pkg::rsp_type                   rsp_item
);

   localparam int SLOTS    = 1 << TABLE_BITS;
   localparam int HALF_MAX = SLOTS / 2;
   localparam int BITS_W   = $clog2(TABLE_BITS + 1);
   localparam int CNT_W    = TABLE_BITS;

   // config
   logic [lphi_pkg::KEY_W-1:0]       mult_ff;
   logic [lphi_pkg::SLOT_BITS_W-1:0] slot_bits_ff;

   // request, hash, probe
   lphi_pkg::req_type          req_ff;
   logic [63:0]                prod_ff, prod_in;
   logic [63:0]                acc_ff, acc_in;
   logic [TABLE_BITS-1:0]      probe_addr_ff, probe_addr_in;
   logic [TABLE_BITS-1:0]      probe_n_ff, probe_n_in;
   logic [TABLE_BITS-1:0]      clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   lphi_pkg::entry_type        rd_ff;
   logic                       rsp_strobe_ff;
   lphi_pkg::rsp_type          rsp_item_ff, rsp_item_in;

   lphi_pkg::entry_type        mem [SLOTS];

   logic [BITS_W-1:0]          bits_c;
   logic [TABLE_BITS-1:0]      mask_c;
   logic [TABLE_BITS-1:0]      home_c;
   logic [63:0]                home_wide_c;
   logic [6:0]                 shift_c;
   logic [CNT_W-1:0]           half_c;
   logic [31:0]                mul_a_c, mul_b_c;
   logic                       mem_we_c;
   logic [TABLE_BITS-1:0]      mem_waddr_c;
   lphi_pkg::entry_type        mem_wdata_c;

   // slot bits in use, clamped to 4..TABLE_BITS
   always_comb begin
      if (slot_bits_ff < lphi_pkg::SLOT_BITS_W'(lphi_pkg::MIN_SLOT_BITS)) begin
         bits_c = BITS_W'(lphi_pkg::MIN_SLOT_BITS);
      end else if (32'(slot_bits_ff) > TABLE_BITS) begin
         bits_c = BITS_W'(TABLE_BITS);
      end else begin
         bits_c = BITS_W'(slot_bits_ff);
      end
      mask_c      = ~({TABLE_BITS{1'b1}} << bits_c);
      half_c      = CNT_W'(1) << (bits_c - BITS_W'(1));
      shift_c     = 7'd64 - 7'(bits_c);
      home_wide_c = acc_ff >> shift_c;
      home_c      = home_wide_c[TABLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff      <= lphi_pkg::HASH_MULT_RESET;
         slot_bits_ff <= lphi_pkg::SLOT_BITS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lphi_pkg::CSR_HASH_MULT: mult_ff      <= csr_wdata;
            lphi_pkg::CSR_SLOT_BITS: slot_bits_ff <= csr_wdata[lphi_pkg::SLOT_BITS_W-1:0];
            default: ;
         endcase
      end
   end

   // one 32x32 multiplier, low 64 bits of key * mult over four phases
   always_comb begin
      unique case (cmd.mul_phase)
         lphi_pkg::MUL_LL: begin
            mul_a_c = req_ff.key[31:0];
            mul_b_c = mult_ff[31:0];
         end
         lphi_pkg::MUL_LH: begin
            mul_a_c = req_ff.key[31:0];
            mul_b_c = mult_ff[63:32];
         end
         default: begin
            mul_a_c = req_ff.key[63:32];
            mul_b_c = mult_ff[31:0];
         end
      endcase
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (cmd.mul_en) begin
         prod_in = {32'b0, mul_a_c} * {32'b0, mul_b_c};
         unique case (cmd.mul_phase)
            lphi_pkg::MUL_LL: ;
            lphi_pkg::MUL_LH: acc_in = prod_ff;
            default:          acc_in = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
         endcase
      end
   end

   always_comb begin
      probe_addr_in = probe_addr_ff;
      probe_n_in    = probe_n_ff;
      if (cmd.set_home) begin
         probe_addr_in = home_c;
         probe_n_in    = '0;
      end else if (cmd.adv) begin
         probe_addr_in = (probe_addr_ff + TABLE_BITS'(1)) & mask_c;
         probe_n_in    = probe_n_ff + TABLE_BITS'(1);
      end
      clr_addr_in = cmd.sweep ? clr_addr_ff + TABLE_BITS'(1) : clr_addr_ff;
      count_in    = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.wr) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      mem_we_c    = cmd.sweep | cmd.wr;
      mem_waddr_c = cmd.sweep ? clr_addr_ff : probe_addr_ff;
      mem_wdata_c = '0;
      if (!cmd.sweep) begin
         mem_wdata_c.used  = 1'b1;
         mem_wdata_c.value = lphi_pkg::VALUE_W'(count_ff);
         mem_wdata_c.key   = req_ff.key;
      end
   end

   always_comb begin
      rsp_item_in        = rsp_item_ff;
      rsp_item_in.status = cmd.rsp_status;
      unique case (cmd.rsp_val)
         lphi_pkg::VAL_COUNT: rsp_item_in.value = lphi_pkg::VALUE_W'(count_ff);
         lphi_pkg::VAL_SLOT:  rsp_item_in.value = rd_ff.value;
         default:             rsp_item_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_addr_ff   <= clr_addr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.rsp_load) begin
         rsp_item_ff <= rsp_item_in;
      end
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      probe_addr_ff <= probe_addr_in;
      probe_n_ff    <= probe_n_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we_c) begin
         mem[mem_waddr_c] <= mem_wdata_c;
      end
      if (cmd.rd) begin
         rd_ff <= mem[probe_addr_ff];
      end
   end

   assign stat.action       = req_ff.action;
   assign stat.key_reserved = (req_ff.key == lphi_pkg::RESERVED_KEY);
   assign stat.slot_used    = rd_ff.used;
   assign stat.key_match    = (rd_ff.key == req_ff.key);
   assign stat.probe_last   = (probe_n_ff == mask_c);
   assign stat.sweep_last   = (clr_addr_ff == {TABLE_BITS{1'b1}});
   assign stat.full         = (count_ff >= half_c);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   `LPHI_ASSERT_IMPL(a_wr_empty_slot, cmd.wr, !rd_ff.used && !stat.full, "insert into used slot or full table")
   `LPHI_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(HALF_MAX), "entry count beyond half the table")
   `LPHI_ASSERT_NEXT(a_strobe_single, rsp_strobe_ff, !rsp_strobe_ff, "result strobes back to back")

endmodule

// ===== design/lphi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphi_ctrl
// Sequencer: clear sweep, hash phases, probe loop and result issue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lphi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lphi_pkg::stat_type stat,
   output lphi_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_CLEAR,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_HOME,
      S_READ,
      S_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = lphi_pkg::ST_DONE;
      cmd.rsp_val    = lphi_pkg::VAL_ZERO;
      cmd.mul_phase  = lphi_pkg::MUL_LL;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.action)
               lphi_pkg::ACT_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_CLEAR;
               end
               lphi_pkg::ACT_INSERT: begin
                  if (stat.key_reserved) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = lphi_pkg::ST_RESERVED;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_MUL0;
                  end
               end
               lphi_pkg::ACT_LOOKUP: begin
                  if (stat.key_reserved) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = lphi_pkg::ST_NOT_FOUND;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_MUL0;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_MUL0: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = lphi_pkg::MUL_LL;
            state_in      = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = lphi_pkg::MUL_LH;
            state_in      = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = lphi_pkg::MUL_HL;
            state_in      = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = lphi_pkg::MUL_ACC;
            state_in      = S_HOME;
         end
         S_HOME: begin
            cmd.set_home = 1'b1;
            state_in     = S_READ;
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_IDLE;
            priority if (!stat.slot_used) begin
               cmd.rsp_load = 1'b1;
               if (stat.action == lphi_pkg::ACT_INSERT) begin
                  if (stat.full) begin
                     cmd.rsp_status = lphi_pkg::ST_FULL;
                  end else begin
                     cmd.wr      = 1'b1;
                     cmd.rsp_val = lphi_pkg::VAL_COUNT;
                  end
               end else begin
                  cmd.rsp_status = lphi_pkg::ST_NOT_FOUND;
               end
            end else if (stat.key_match) begin
               cmd.rsp_load = 1'b1;
               if (stat.action == lphi_pkg::ACT_INSERT) begin
                  cmd.rsp_status = lphi_pkg::ST_DUPLICATE;
               end else begin
                  cmd.rsp_status = lphi_pkg::ST_FOUND;
                  cmd.rsp_val    = lphi_pkg::VAL_SLOT;
               end
            end else if (stat.probe_last) begin
               // every slot in use holds another key
               cmd.rsp_load = 1'b1;
               if (stat.action == lphi_pkg::ACT_INSERT) begin
                  cmd.rsp_status = lphi_pkg::ST_FULL;
               end else begin
                  cmd.rsp_status = lphi_pkg::ST_NOT_FOUND;
               end
            end else begin
               cmd.adv  = 1'b1;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

   `LPHI_ASSERT_NEXT(a_accept_decode, start && !busy_ff, busy_ff && state_ff == S_DECODE, "accepted transfer not decoded")
   `LPHI_ASSERT_IMPL(a_sweep_busy, state_ff == S_INIT || state_ff == S_CLEAR, busy_ff && !cmd.load, "transfer taken during sweep")

endmodule

// ===== design/linear_probe_hash_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_index
// Hash index mapping 64-bit keys to dense sequence numbers, linear probing.
// ----------------------------------------------------------------------------
// A command transfer is taken when start is high and busy is low. Each command
// gives exactly one result, shown on rsp_item for a single cycle with
// rsp_strobe high; there is no back-pressure, so the receiver must take it
// then. One command is in flight at a time. An unused action code, or an
// insert or lookup of the reserved (all-ones) key, is answered from S_DECODE;
// any other insert or lookup steps through S_DECODE, S_MUL0 to S_MUL3 and
// S_HOME, then S_READ and S_CHECK for each probe; a clear sweeps every slot
// in S_CLEAR. The result strobe is registered. Next accept can follow in the
// cycle the strobe is shown. The hash runs on a single 32x32 multiplier
// (three partial products, low 64 bits kept) and each probe is a registered
// memory read followed by a compare. After reset, busy stays high while the
// slot memory is swept empty; a clear command runs the same sweep. Config
// writes on the csr_ port are taken any cycle but must only be done while
// idle. slot_bits is clamped to 4..TABLE_BITS. A refused insert leaves the
// table untouched; software must issue a clear to discard it.
// ----------------------------------------------------------------------------

module linear_probe_hash_index #(
   parameter int TABLE_BITS = lphi_pkg::TABLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command transfer
   input  logic                            start,
   output logic                            busy,
   input  lphi_pkg::req_type               req_item,
   // result transfer
   output logic                            rsp_strobe,
   output lphi_pkg::rsp_type               rsp_item,
   // register writes
   input  logic                            csr_we,
   input  logic [lphi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lphi_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lphi_pkg::cmd_type  cmd;   // sequencer commands
   lphi_pkg::stat_type stat;  // datapath status

   lphi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lphi_datapath #(
      .TABLE_BITS (TABLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== sim/tb_linear_probe_hash_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_index
// Self-checking bench for the linear-probe hash index. A short directed table
// (empty table, duplicates, reserved key, table full, clamped slot_bits, a
// degenerate hash) is followed by random phases with fresh settings, each
// result checked field by field against a local model of the table.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_index;
   import lphi_pkg::*;

   localparam int SLOTS        = 1 << TABLE_BITS_DEF;
   localparam int RANDOM_OPS   = 1200;
   // quiet time after the last result; any stray strobe shows up here
   localparam int DRAIN_CYCLES = SLOTS + 64;
   localparam int POOL_DEPTH   = 48;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   logic                   busy;
   req_type                req_item   = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_item;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   linear_probe_hash_index i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Table model: a private copy of the settings and of the slot store.
   // Key and sequence entries are only ever read where the slot is occupied.
   // ------------------------------------------------------------------------
   logic [KEY_W-1:0]       hash_mult_cfg = HASH_MULT_RESET;
   logic [SLOT_BITS_W-1:0] slot_bits_cfg = SLOT_BITS_RESET;
   logic [KEY_W-1:0]       slot_key [SLOTS];
   logic [VALUE_W-1:0]     slot_seq [SLOTS];
   logic [SLOTS-1:0]       slot_taken    = '0;
   logic [10:0]            entry_count   = '0;

   rsp_type                outcome_fifo [$];   // predicted results, oldest first
   logic [KEY_W-1:0]       key_pool [$];       // keys seen recently, for repeats
   int                     fail_count    = 0;
   int unsigned            burst_left    = 0;

   // slot_bits saturates to 4..TABLE_BITS
   function automatic int unsigned active_bits();
      int unsigned b;
      b = slot_bits_cfg;
      if (b < MIN_SLOT_BITS) b = MIN_SLOT_BITS;
      if (b > TABLE_BITS_DEF) b = TABLE_BITS_DEF;
      return b;
   endfunction

   // Walk from the home slot; hit means the key sits at pos, otherwise pos is
   // the first free slot met (or the home slot again if none was free).
   function automatic bit probe_chain(input logic [KEY_W-1:0] key,
                                      output int unsigned pos);
      int unsigned      bits;
      int unsigned      mask;
      int unsigned      s;
      logic [KEY_W-1:0] prod;
      bits = active_bits();
      mask = (1 << bits) - 1;
      prod = key * hash_mult_cfg;                // modulo 2^64
      s    = 32'(prod >> (KEY_W - bits)) & mask;
      for (int n = 0; n < (1 << bits); n++) begin
         if (!slot_taken[s]) begin
            pos = s;
            return 1'b0;
         end
         if (slot_key[s] == key) begin
            pos = s;
            return 1'b1;
         end
         s = (s + 1) & mask;
      end
      pos = s;
      return 1'b0;
   endfunction

   // Applies one command to the model and returns the result it should give.
   function automatic rsp_type predict_outcome(input req_type cmd);
      rsp_type     res;
      int unsigned pos;
      int unsigned half;
      res.status = ST_DONE;
      res.value  = '0;
      case (cmd.action)
         ACT_CLEAR: begin
            slot_taken  = '0;
            entry_count = '0;
         end
         ACT_INSERT: begin
            half = (1 << active_bits()) >> 1;
            // refusals in priority order: reserved, duplicate, full
            if (cmd.key == RESERVED_KEY) begin
               res.status = ST_RESERVED;
            end else if (probe_chain(cmd.key, pos)) begin
               res.status = ST_DUPLICATE;
            end else if (entry_count >= half || slot_taken[pos]) begin
               res.status = ST_FULL;
            end else begin
               slot_key[pos]   = cmd.key;
               slot_seq[pos]   = entry_count[VALUE_W-1:0];
               slot_taken[pos] = 1'b1;
               res.value       = entry_count[VALUE_W-1:0];
               entry_count     = entry_count + 1'b1;
            end
         end
         ACT_LOOKUP: begin
            // the reserved key never matches anything
            if (cmd.key != RESERVED_KEY && probe_chain(cmd.key, pos)) begin
               res.status = ST_FOUND;
               res.value  = slot_seq[pos];
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         default: ;                               // unused code: no-op
      endcase
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      // small keys now and then so repeats and near neighbours turn up
      if ($urandom_range(0, 3) == 0) return 64'($urandom_range(0, 255));
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] pool_key();
      if (key_pool.size() == 0) return random_key();
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
   endfunction

   // Sender pacing: bursts of back-to-back commands separated by idle gaps;
   // some new bursts start with no gap, giving longer runs without idling.
   function automatic int unsigned next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(1, 15);
   endfunction

   // ------------------------------------------------------------------------
   // Command transfer. Inputs move on the falling edge; the transfer is seen
   // at the rising edge with start high and busy low, and the model is
   // stepped right there. start is left high after a transfer so that the
   // next command can follow back to back; only a gap or settle() lowers it.
   // ------------------------------------------------------------------------
   task automatic issue(input req_type cmd, input bit typed, input rsp_type typed_rsp);
      rsp_type     predicted;
      req_type     junk;
      int unsigned gap;
      gap = next_gap();
      repeat (gap) begin
         @(negedge clock);
         junk.action = action_type'($urandom_range(0, 3));
         junk.key    = {$urandom, $urandom};
         start    <= 1'b0;
         req_item <= junk;                        // garbage while start is low
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= cmd;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_outcome(cmd);
      outcome_fifo.push_back(typed ? typed_rsp : predicted);
   endtask

   // Drop start and wait until every result is in and the block is idle.
   // Each command yields exactly one result, so an empty queue plus busy low
   // is a safe point for register writes.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (outcome_fifo.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_index <= CSR_IDX_W'($urandom);
      csr_wdata <= {$urandom, $urandom};
      if (idx == CSR_HASH_MULT) hash_mult_cfg = data;
      else                      slot_bits_cfg = data[SLOT_BITS_W-1:0];
   endtask

   // ------------------------------------------------------------------------
   // Directed table. A row is either a register write or a command; commands
   // carry a hand-written result only where it is obvious, else the model
   // decides.
   // ------------------------------------------------------------------------
   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
      req_type               cmd;
      bit                    typed;
      rsp_type               typed_rsp;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic void add_op_typed(input action_type act, input logic [KEY_W-1:0] key,
                                        input status_type st, input int unsigned val);
      dir_row_type row;
      row                  = '{is_csr: 1'b0, csr_idx: '0, csr_data: '0, cmd: '0,
                               typed: 1'b0, typed_rsp: '0};
      row.cmd.action       = act;
      row.cmd.key          = key;
      row.typed            = 1'b1;
      row.typed_rsp.status = st;
      row.typed_rsp.value  = VALUE_W'(val);
      dir_rows.push_back(row);
   endfunction

   function automatic void add_op(input action_type act, input logic [KEY_W-1:0] key);
      dir_row_type row;
      row            = '{is_csr: 1'b0, csr_idx: '0, csr_data: '0, cmd: '0,
                         typed: 1'b0, typed_rsp: '0};
      row.cmd.action = act;
      row.cmd.key    = key;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      dir_row_type row;
      row          = '{is_csr: 1'b0, csr_idx: '0, csr_data: '0, cmd: '0,
                       typed: 1'b0, typed_rsp: '0};
      row.is_csr   = 1'b1;
      row.csr_idx  = idx;
      row.csr_data = data;
      dir_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------------
   // Result checker: every strobe is a transfer that cannot be held off, so
   // it is compared against the oldest prediction on the same rising edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (outcome_fifo.size() == 0) begin
            $error("result with nothing outstanding: status %0d value %0d",
                   rsp_item.status, rsp_item.value);
            fail_count++;
         end else begin
            want = outcome_fifo.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.value !== want.value) begin
               $error("value mismatch: expected %0d, actual %0d",
                      want.value, rsp_item.value);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      dir_row_type      row;
      req_type          cmd;
      rsp_type          no_rsp;
      logic [KEY_W-1:0] fill_keys [8];
      logic [KEY_W-1:0] mult;
      logic [3:0]       bits_sel;
      int unsigned      ops_done;
      int unsigned      phase_len;
      int unsigned      pick;

      no_rsp    = '0;
      fill_keys = '{64'd1, 64'd2, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFE, 64'd3, 64'd4, 64'd5};

      // default settings, fresh table
      add_op_typed(ACT_LOOKUP, 64'd0, ST_NOT_FOUND, 0);
      add_op_typed(ACT_INSERT, 64'd0, ST_DONE, 0);
      add_op_typed(ACT_INSERT, 64'd0, ST_DUPLICATE, 0);
      add_op_typed(ACT_LOOKUP, 64'd0, ST_FOUND, 0);
      add_op_typed(ACT_INSERT, RESERVED_KEY, ST_RESERVED, 0);
      add_op_typed(ACT_LOOKUP, RESERVED_KEY, ST_NOT_FOUND, 0);
      add_op_typed(ACT_NOP, 64'h5555_5555_5555_5555, ST_DONE, 0);
      add_op_typed(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, ST_DONE, 1);
      add_op(ACT_LOOKUP, 64'h8000_0000_0000_0000);
      add_op_typed(ACT_CLEAR, 64'hAAAA_AAAA_AAAA_AAAA, ST_DONE, 0);
      // zero multiplier sends every key home to slot 0: one long probe chain.
      // slot_bits 0 clamps to 4, so 16 slots and room for 8 entries.
      add_csr(CSR_HASH_MULT, '0);
      add_csr(CSR_SLOT_BITS, '0);
      foreach (fill_keys[i]) add_op_typed(ACT_INSERT, fill_keys[i], ST_DONE, i);
      add_op_typed(ACT_INSERT, 64'd9, ST_FULL, 0);
      add_op(ACT_LOOKUP, fill_keys[7]);
      add_op(ACT_LOOKUP, 64'd100);
      // all-ones write: slot_bits 15 clamps to 10, the upper bits are dropped;
      // the range grows under a populated table
      add_csr(CSR_SLOT_BITS, '1);
      add_op(ACT_LOOKUP, 64'd1);
      add_csr(CSR_HASH_MULT, '1);
      add_op_typed(ACT_CLEAR, 64'd0, ST_DONE, 0);

      // single reset at the start; busy covers the sweep that follows it
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_csr) begin
            settle();
            write_csr(row.csr_idx, row.csr_data);
         end else begin
            issue(row.cmd, row.typed, row.typed_rsp);
         end
      end

      // Random phases. Each picks new settings (mostly small tables to keep
      // clear sweeps and probe chains short), usually starts from a clear,
      // then runs a mix weighted towards real inserts and lookups of keys
      // that are already in the table.
      ops_done = 0;
      while (ops_done < RANDOM_OPS) begin
         settle();
         case ($urandom_range(0, 9))
            0:       mult = '0;
            1:       mult = '1;
            2:       mult = 64'd1;
            3:       mult = HASH_MULT_RESET;
            default: mult = {$urandom, $urandom} | 64'd1;
         endcase
         pick = $urandom_range(0, 19);
         if (pick < 2)       bits_sel = 4'($urandom_range(0, 3));
         else if (pick == 2) bits_sel = 4'($urandom_range(11, 15));
         else if (pick < 5)  bits_sel = 4'($urandom_range(7, 10));
         else                bits_sel = 4'($urandom_range(4, 6));
         if ($urandom_range(0, 3) != 0) write_csr(CSR_HASH_MULT, mult);
         write_csr(CSR_SLOT_BITS, ({$urandom, $urandom} & ~64'hF) | 64'(bits_sel));

         // sometimes keep the old contents under the new hash and range
         if ($urandom_range(0, 9) < 7) begin
            cmd.action = ACT_CLEAR;
            cmd.key    = random_key();
            issue(cmd, 1'b0, no_rsp);
            ops_done++;
         end

         phase_len = $urandom_range(10, 50);
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            cmd.key = random_key();
            if (pick < 40) begin
               cmd.action = ACT_INSERT;
               key_pool.push_back(cmd.key);
               if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
            end else if (pick < 52) begin
               cmd.action = ACT_INSERT;             // likely duplicate
               cmd.key    = pool_key();
            end else if (pick < 72) begin
               cmd.action = ACT_LOOKUP;             // likely hit
               cmd.key    = pool_key();
            end else if (pick < 84) begin
               cmd.action = ACT_LOOKUP;             // likely miss
            end else if (pick < 88) begin
               cmd.action = (pick % 2 == 0) ? ACT_INSERT : ACT_LOOKUP;
               cmd.key    = RESERVED_KEY;
            end else if (pick < 91) begin
               cmd.action = ACT_NOP;
            end else if (pick < 94) begin
               cmd.action = ACT_CLEAR;
            end else begin
               cmd.action = action_type'($urandom_range(0, 3));
               cmd.key    = {$urandom, $urandom};
            end
            issue(cmd, 1'b0, no_rsp);
            if (cmd.action != ACT_NOP) ops_done++;
         end
      end

      // put the registers back to their reset values for a final phase
      settle();
      write_csr(CSR_HASH_MULT, HASH_MULT_RESET);
      write_csr(CSR_SLOT_BITS, 64'(SLOT_BITS_RESET));
      cmd.action = ACT_LOOKUP;
      cmd.key    = pool_key();
      issue(cmd, 1'b0, no_rsp);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog: well beyond the slowest legal run (every command a full-table
   // probe chain)
   initial begin
      #200_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
